>>> rtl/sbpm_pkg.sv
// Shared types and constants for the servo bus packet master.
// Item structs, operation and status codes, queue entry format.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbpm_pkg;

  // Timeout counter width (8..32)
  localparam int TIMEOUT_WIDTH = 16;

  // Front-to-back queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Config port
  localparam int CFG_AW = 4;
  localparam logic [1:0] REG_START_ID = 2'd0;
  localparam logic [1:0] REG_LONG_TO  = 2'd1;
  localparam logic [1:0] REG_SHORT_TO = 2'd2;

  // Operation codes; OP_IDLE doubles as "no pending command"
  typedef enum logic [2:0] {
    OP_PING    = 3'd0,
    OP_WR_BYTE = 3'd1,
    OP_WR_WORD = 3'd2,
    OP_RD_BYTE = 3'd3,
    OP_RD_WORD = 3'd4,
    OP_RX_BYTE = 3'd5,
    OP_TICK    = 3'd6,
    OP_IDLE    = 3'd7
  } op_t;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;

  localparam logic KIND_TX   = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  servo_reg;
    logic [15:0] write_value;
    logic [7:0]  probe_id;
    logic [7:0]  rx_data;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  tx_data;
    logic        tx_last;
    logic [1:0]  status;
    logic [15:0] read_value;
    logic        ping_found;
  } out_item_t;

  // One job: either a whole request packet or one completion
  typedef struct packed {
    logic        is_done;
    op_t         cmd;
    logic [7:0]  id;
    logic [7:0]  servo_reg;
    logic [15:0] value;
    logic [1:0]  status;
    logic [15:0] read_value;
    logic        ping_found;
  } job_t;

endpackage

`default_nettype wire

>>> rtl/sbpm_queue.sv
// Short job queue between the front and back of the servo bus master.
// Register-based FIFO of sbpm_pkg::job_t entries. Depends on sbpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbpm_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sbpm_pkg::job_t push_job,
  input  logic          pop,
  output sbpm_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);
  import sbpm_pkg::*;

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full     = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("job popped from empty queue");
`endif

endmodule

`default_nettype wire

>>> rtl/sbpm_front.sv
// Front end: accepts items, keeps command/response state and config registers,
// and pushes packet or completion jobs. Depends on sbpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbpm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sbpm_pkg::in_item_t    in_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [sbpm_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  input  logic                  q_full,
  output logic                  q_push,
  output sbpm_pkg::job_t        q_job
);
  import sbpm_pkg::*;

  logic [7:0]               start_id_r, start_id_nxt;
  logic [15:0]              long_to_r, long_to_nxt;
  logic [15:0]              short_to_r, short_to_nxt;
  logic [7:0]               cur_id_r, cur_id_nxt;
  op_t                      pend_cmd_r, pend_cmd_nxt;
  logic [7:0]               pend_reg_r, pend_reg_nxt;
  logic [15:0]              pend_val_r, pend_val_nxt;
  logic [7:0]               pend_probe_r, pend_probe_nxt;
  logic [3:0]               rx_count_r, rx_count_nxt;
  logic                     hdr_good_r, hdr_good_nxt;
  logic [7:0]               data_lo_r, data_lo_nxt;
  logic [7:0]               data_hi_r, data_hi_nxt;
  logic [TIMEOUT_WIDTH-1:0] ticks_r, ticks_nxt;

  logic       accept;
  logic       cfg_wr;
  logic       busy;
  op_t        op;
  logic [3:0] rx_inc;
  logic [3:0] need;
  logic       finish;
  logic [1:0] fin_st;
  logic       start_send;

  // Saturate a 16-bit register value into the timeout counter
  function automatic logic [TIMEOUT_WIDTH-1:0] to_load(input logic [15:0] v);
    logic [TIMEOUT_WIDTH-1:0] tmax;
    tmax = '1;
    if (32'(v) > 32'(tmax)) begin
      to_load = tmax;
    end else begin
      to_load = TIMEOUT_WIDTH'(v);
    end
  endfunction

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_START_ID: cfg_prdata = {24'd0, start_id_r};
      REG_LONG_TO:  cfg_prdata = {16'd0, long_to_r};
      REG_SHORT_TO: cfg_prdata = {16'd0, short_to_r};
      default:      cfg_prdata = '0;
    endcase
  end

  always_comb begin
    start_id_nxt   = start_id_r;
    long_to_nxt    = long_to_r;
    short_to_nxt   = short_to_r;
    cur_id_nxt     = cur_id_r;
    pend_cmd_nxt   = pend_cmd_r;
    pend_reg_nxt   = pend_reg_r;
    pend_val_nxt   = pend_val_r;
    pend_probe_nxt = pend_probe_r;
    rx_count_nxt   = rx_count_r;
    hdr_good_nxt   = hdr_good_r;
    data_lo_nxt    = data_lo_r;
    data_hi_nxt    = data_hi_r;
    ticks_nxt      = ticks_r;
    q_push         = 1'b0;
    q_job          = '0;
    finish         = 1'b0;
    fin_st         = ST_GOOD;
    start_send     = 1'b0;

    op     = op_t'(in_data.operation);
    busy   = (pend_cmd_r != OP_IDLE);
    rx_inc = rx_count_r + 4'd1;
    need   = (pend_cmd_r == OP_RD_BYTE) ? 4'd7 :
             (pend_cmd_r == OP_RD_WORD) ? 4'd8 : 4'd6;

    if (accept) begin
      unique case (op) inside
        OP_PING, OP_WR_BYTE, OP_WR_WORD, OP_RD_BYTE, OP_RD_WORD: begin
          if (!busy) begin
            pend_cmd_nxt   = op;
            pend_reg_nxt   = in_data.servo_reg;
            pend_val_nxt   = in_data.write_value;
            pend_probe_nxt = in_data.probe_id;
            start_send     = 1'b1;
          end
        end
        OP_RX_BYTE: begin
          if (busy) begin
            if (rx_count_r < 4'd2 && in_data.rx_data != 8'hFF) begin
              hdr_good_nxt = 1'b0;
            end
            if (rx_count_r == 4'd5) begin
              data_lo_nxt = in_data.rx_data;
            end
            if (rx_count_r == 4'd6) begin
              data_hi_nxt = in_data.rx_data;
            end
            rx_count_nxt = rx_inc;
            if (rx_inc >= need) begin
              finish = 1'b1;
              fin_st = hdr_good_nxt ? ST_GOOD : ST_BAD;
            end
          end
        end
        OP_TICK: begin
          if (busy) begin
            if (ticks_r <= TIMEOUT_WIDTH'(1)) begin
              finish = 1'b1;
              fin_st = ST_TIMEOUT;
            end else begin
              ticks_nxt = ticks_r - TIMEOUT_WIDTH'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (finish) begin
      if (pend_cmd_r == OP_WR_WORD && fin_st != ST_GOOD) begin
        // word write retries until the header comes back good
        start_send = 1'b1;
      end else begin
        q_push             = 1'b1;
        q_job.is_done      = 1'b1;
        q_job.cmd          = pend_cmd_r;
        q_job.status       = fin_st;
        q_job.ping_found   = (pend_cmd_r == OP_PING) && (fin_st != ST_TIMEOUT);
        if (fin_st == ST_GOOD) begin
          if (pend_cmd_r == OP_RD_BYTE) begin
            q_job.read_value = {8'd0, data_lo_nxt};
          end else if (pend_cmd_r == OP_RD_WORD) begin
            q_job.read_value = {data_hi_nxt, data_lo_nxt};
          end else if (pend_cmd_r == OP_PING) begin
            cur_id_nxt = pend_probe_r;
          end
        end
        pend_cmd_nxt = OP_IDLE;
        rx_count_nxt = '0;
        ticks_nxt    = '0;
      end
    end

    if (start_send) begin
      q_push          = 1'b1;
      q_job.is_done   = 1'b0;
      q_job.cmd       = pend_cmd_nxt;
      q_job.id        = (pend_cmd_nxt == OP_PING) ? pend_probe_nxt : cur_id_r;
      q_job.servo_reg = pend_reg_nxt;
      q_job.value     = pend_val_nxt;
      rx_count_nxt    = '0;
      hdr_good_nxt    = 1'b1;
      data_lo_nxt     = '0;
      data_hi_nxt     = '0;
      ticks_nxt       = (pend_cmd_nxt == OP_WR_WORD || pend_cmd_nxt == OP_RD_BYTE) ?
                        to_load(short_to_r) : to_load(long_to_r);
    end

    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_START_ID: begin
          start_id_nxt = cfg_pwdata[7:0];
          cur_id_nxt   = cfg_pwdata[7:0];
        end
        REG_LONG_TO:  long_to_nxt  = cfg_pwdata[15:0];
        REG_SHORT_TO: short_to_nxt = cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_id_r   <= 8'd1;
      long_to_r    <= 16'd500;
      short_to_r   <= 16'd100;
      cur_id_r     <= 8'd1;
      pend_cmd_r   <= OP_IDLE;
      pend_reg_r   <= '0;
      pend_val_r   <= '0;
      pend_probe_r <= '0;
      rx_count_r   <= '0;
      hdr_good_r   <= 1'b1;
      data_lo_r    <= '0;
      data_hi_r    <= '0;
      ticks_r      <= '0;
    end else begin
      start_id_r   <= start_id_nxt;
      long_to_r    <= long_to_nxt;
      short_to_r   <= short_to_nxt;
      cur_id_r     <= cur_id_nxt;
      pend_cmd_r   <= pend_cmd_nxt;
      pend_reg_r   <= pend_reg_nxt;
      pend_val_r   <= pend_val_nxt;
      pend_probe_r <= pend_probe_nxt;
      rx_count_r   <= rx_count_nxt;
      hdr_good_r   <= hdr_good_nxt;
      data_lo_r    <= data_lo_nxt;
      data_hi_r    <= data_hi_nxt;
      ticks_r      <= ticks_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_cmd_r == OP_IDLE) |-> (rx_count_r == '0 && ticks_r == '0))
    else $error("idle with stale response count or timer");

  a_rx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_cmd_r != OP_IDLE) |-> (rx_count_r < 4'd8))
    else $error("response count past longest response");
`endif

endmodule

`default_nettype wire

>>> rtl/sbpm_back.sv
// Back end: pops jobs, drives the result register (one item per cycle unless
// out_stall), serializes request packets and checksums. Depends on sbpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbpm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  sbpm_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output sbpm_pkg::out_item_t out_data
);
  import sbpm_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;
  logic      busy_r, busy_nxt;
  logic [3:0] idx_r, idx_nxt;
  job_t      job_r, job_nxt;
  logic [7:0] ck_r, ck_nxt;

  logic       out_free;
  logic       at_last;

  function automatic logic [7:0] pkt_len(input op_t c);
    case (c)
      OP_PING:    pkt_len = 8'h02;
      OP_WR_WORD: pkt_len = 8'h05;
      default:    pkt_len = 8'h04;
    endcase
  endfunction

  function automatic logic [7:0] pkt_instr(input op_t c);
    case (c) inside
      OP_PING:              pkt_instr = 8'h01;
      OP_WR_BYTE, OP_WR_WORD: pkt_instr = 8'h03;
      default:              pkt_instr = 8'h02;
    endcase
  endfunction

  // Second parameter byte: write low byte, or read length
  function automatic logic [7:0] pkt_p2(input job_t j);
    case (j.cmd)
      OP_RD_BYTE: pkt_p2 = 8'h01;
      OP_RD_WORD: pkt_p2 = 8'h02;
      default:    pkt_p2 = j.value[7:0];
    endcase
  endfunction

  function automatic logic [3:0] last_idx(input op_t c);
    case (c)
      OP_PING:    last_idx = 4'd5;
      OP_WR_WORD: last_idx = 4'd8;
      default:    last_idx = 4'd7;
    endcase
  endfunction

  function automatic logic [7:0] pkt_cksum(input job_t j);
    logic [7:0] s;
    s = j.id + pkt_len(j.cmd) + pkt_instr(j.cmd);
    if (j.cmd != OP_PING) begin
      s = s + j.servo_reg + pkt_p2(j);
    end
    if (j.cmd == OP_WR_WORD) begin
      s = s + j.value[15:8];
    end
    pkt_cksum = ~s;
  endfunction

  function automatic logic [7:0] pkt_byte(input job_t j, input logic [3:0] i,
                                          input logic [7:0] ck);
    case (i)
      4'd0, 4'd1: pkt_byte = 8'hFF;
      4'd2:       pkt_byte = j.id;
      4'd3:       pkt_byte = pkt_len(j.cmd);
      4'd4:       pkt_byte = pkt_instr(j.cmd);
      4'd5:       pkt_byte = (j.cmd == OP_PING) ? ck : j.servo_reg;
      4'd6:       pkt_byte = pkt_p2(j);
      4'd7:       pkt_byte = (j.cmd == OP_WR_WORD) ? j.value[15:8] : ck;
      default:    pkt_byte = ck;
    endcase
  endfunction

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign at_last   = (idx_r == last_idx(job_r.cmd));

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    job_nxt       = job_r;
    ck_nxt        = ck_r;
    q_pop         = 1'b0;

    if (out_free) begin
      if (busy_r) begin
        out_valid_nxt          = 1'b1;
        out_data_nxt           = '0;
        out_data_nxt.result_kind = KIND_TX;
        out_data_nxt.tx_data   = pkt_byte(job_r, idx_r, ck_r);
        out_data_nxt.tx_last   = at_last;
        idx_nxt                = idx_r + 4'd1;
        if (at_last) begin
          busy_nxt = 1'b0;
        end
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        if (q_head.is_done) begin
          out_data_nxt.result_kind = KIND_DONE;
          out_data_nxt.status      = q_head.status;
          out_data_nxt.read_value  = q_head.read_value;
          out_data_nxt.ping_found  = q_head.ping_found;
        end else begin
          // first header byte goes out now, the rest follow from job_r
          out_data_nxt.result_kind = KIND_TX;
          out_data_nxt.tx_data     = 8'hFF;
          job_nxt  = q_head;
          ck_nxt   = pkt_cksum(q_head);
          busy_nxt = 1'b1;
          idx_nxt  = 4'd1;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    job_r      <= job_nxt;
    ck_r       <= ck_nxt;
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r != 4'd0 && idx_r <= last_idx(job_r.cmd)))
    else $error("packet byte index out of range");

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!busy_r && out_free))
    else $error("job popped while a packet is still going out");
`endif

endmodule

`default_nettype wire

>>> rtl/servo_bus_packet_master.sv
// Output: a command's packet goes out byte by byte, one byte per cycle while
//   out_stall is low (6, 8 or 9 bytes); a completion item follows the received
//   byte or tick that ends the command.
// Throughput: one input item per cycle while the 4-entry job queue has room;
//   the back end drains one result per stall-free cycle; a packet sets the pace.
// Reset: synchronous, active-low rst_n; config back to defaults, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

// Top level of the servo bus packet master. Depends on sbpm_pkg and on
// sbpm_front, sbpm_queue and sbpm_back.
//
// Structure:
//   sbpm_front - acts on each input item as it is accepted. It owns the config
//                registers, current id, pending command, response byte count,
//                header check, read data capture and the timeout counter. Each
//                item yields at most one job: a packet to send or a completion.
//   sbpm_queue - four-entry job FIFO. in_stall is raised only while it is full.
//   sbpm_back  - pops a job and drives the output register: a packet job is
//                serialized byte by byte (checksum computed when the job is
//                loaded), a completion job is a single item.
//
// Word writes that see a bad header or a timeout are resent from the front with
// the current id; the completion only goes out on a good header.

module servo_bus_packet_master (
  input  logic                          clk,
  input  logic                          rst_n,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sbpm_pkg::in_item_t            in_data,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output sbpm_pkg::out_item_t           out_data,
  // config port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sbpm_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import sbpm_pkg::*;

  logic q_push;
  job_t q_push_job;
  logic q_pop;
  job_t q_head;
  logic q_full;
  logic q_empty;

  // zero-wait-state register port
  assign cfg_pready = 1'b1;

  sbpm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_push_job)
  );

  sbpm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_push_job),
    .pop      (q_pop),
    .head_job (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  sbpm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_full)
    else $error("input stalled with room in the job queue");
`endif

endmodule

`default_nettype wire

>>> tb/sv/sbpm_checker.sv
// Result checker for the servo bus packet master: snoops config writes and input
// items, predicts every packet byte and completion, and compares each result item.
// Depends on sbpm_pkg.
`timescale 1ns / 1ps

module sbpm_checker
  import sbpm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_item_t            out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [CFG_AW-1:0]    cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  input  logic                 cfg_pready,
  output int                   fail_count,
  output int                   owed_count,
  output logic                 busy
);

  localparam logic [7:0]  HDR_BYTE     = 8'hFF;
  localparam logic [7:0]  LEN_PING     = 8'h02;
  localparam logic [7:0]  LEN_SHORT    = 8'h04;
  localparam logic [7:0]  LEN_WORD_WR  = 8'h05;
  localparam logic [7:0]  INS_PING     = 8'h01;
  localparam logic [7:0]  INS_READ     = 8'h02;
  localparam logic [7:0]  INS_WRITE    = 8'h03;
  localparam logic [7:0]  RD_LEN_BYTE  = 8'h01;
  localparam logic [7:0]  RD_LEN_WORD  = 8'h02;
  localparam logic [3:0]  RSP_STATUS   = 4'd6;
  localparam logic [3:0]  RSP_BYTE     = 4'd7;
  localparam logic [3:0]  RSP_WORD     = 4'd8;
  localparam logic [7:0]  DEF_START_ID = 8'd1;
  localparam logic [15:0] DEF_LONG_TO  = 16'd500;
  localparam logic [15:0] DEF_SHORT_TO = 16'd100;

  // config copy
  logic [7:0]  start_id_q;
  logic [15:0] long_to_q;
  logic [15:0] short_to_q;

  // master state copy
  logic [7:0]               cur_id;
  op_t                      cmd;
  logic [7:0]               cmd_reg;
  logic [15:0]              cmd_value;
  logic [7:0]               cmd_probe;
  logic [3:0]               rx_cnt;
  logic                     hdr_ok;
  logic [7:0]               data_lo;
  logic [7:0]               data_hi;
  logic [TIMEOUT_WIDTH-1:0] ticks_left;

  out_item_t owed_items_q[$];
  out_item_t want;
  bit        field_bad;

  assign busy = (cmd != OP_IDLE);

  function automatic out_item_t make_result(logic kind, logic [7:0] tx, logic last,
                                            logic [1:0] st, logic [15:0] val,
                                            logic found);
    out_item_t r;
    r.result_kind = kind;
    r.tx_data     = tx;
    r.tx_last     = last;
    r.status      = st;
    r.read_value  = val;
    r.ping_found  = found;
    return r;
  endfunction

  // register value clipped to the counter width
  function automatic logic [TIMEOUT_WIDTH-1:0] timer_load(logic [15:0] cfg_ticks);
    longint unsigned cap;
    cap = (64'd1 << TIMEOUT_WIDTH) - 1;
    return (cfg_ticks > cap) ? TIMEOUT_WIDTH'(cap) : TIMEOUT_WIDTH'(cfg_ticks);
  endfunction

  // queue the request packet of the pending command and rearm the response wait
  task automatic emit_request();
    logic [7:0] pkt[9];
    int         n;
    logic [7:0] sum;
    pkt[0] = HDR_BYTE;
    pkt[1] = HDR_BYTE;
    case (cmd)
      OP_PING: begin
        pkt[2] = cmd_probe; pkt[3] = LEN_PING; pkt[4] = INS_PING;
        n = 5;
      end
      OP_WR_BYTE: begin
        pkt[2] = cur_id; pkt[3] = LEN_SHORT; pkt[4] = INS_WRITE;
        pkt[5] = cmd_reg; pkt[6] = cmd_value[7:0];
        n = 7;
      end
      OP_WR_WORD: begin
        pkt[2] = cur_id; pkt[3] = LEN_WORD_WR; pkt[4] = INS_WRITE;
        pkt[5] = cmd_reg; pkt[6] = cmd_value[7:0]; pkt[7] = cmd_value[15:8];
        n = 8;
      end
      OP_RD_BYTE: begin
        pkt[2] = cur_id; pkt[3] = LEN_SHORT; pkt[4] = INS_READ;
        pkt[5] = cmd_reg; pkt[6] = RD_LEN_BYTE;
        n = 7;
      end
      default: begin
        pkt[2] = cur_id; pkt[3] = LEN_SHORT; pkt[4] = INS_READ;
        pkt[5] = cmd_reg; pkt[6] = RD_LEN_WORD;
        n = 7;
      end
    endcase
    sum = 8'd0;
    for (int i = 2; i < n; i++) sum += pkt[i];
    pkt[n] = ~sum;
    n++;
    for (int k = 0; k < n; k++)
      owed_items_q.push_back(make_result(KIND_TX, pkt[k], k == n - 1, ST_GOOD, 16'd0, 1'b0));
    rx_cnt     = 4'd0;
    hdr_ok     = 1'b1;
    data_lo    = 8'd0;
    data_hi    = 8'd0;
    ticks_left = timer_load((cmd == OP_WR_WORD || cmd == OP_RD_BYTE) ? short_to_q : long_to_q);
  endtask

  // end of a response wait; word writes resend until the header is good
  task automatic close_command(logic [1:0] st);
    logic [15:0] val;
    logic        found;
    if (cmd == OP_WR_WORD && st != ST_GOOD) begin
      emit_request();
    end else begin
      val   = 16'd0;
      found = 1'b0;
      if (st == ST_GOOD) begin
        case (cmd)
          OP_RD_BYTE: val = {8'd0, data_lo};
          OP_RD_WORD: val = {data_hi, data_lo};
          OP_PING:    cur_id = cmd_probe;
          default:    val = 16'd0;
        endcase
      end
      if (cmd == OP_PING) found = (st != ST_TIMEOUT);
      cmd        = OP_IDLE;
      rx_cnt     = 4'd0;
      ticks_left = '0;
      owed_items_q.push_back(make_result(KIND_DONE, 8'd0, 1'b0, st, val, found));
    end
  endtask

  task automatic advance_master(in_item_t it);
    logic [3:0] need;
    if (it.operation <= OP_RD_WORD) begin
      // commands while busy are dropped
      if (cmd == OP_IDLE) begin
        cmd       = op_t'(it.operation);
        cmd_reg   = it.servo_reg;
        cmd_value = it.write_value;
        cmd_probe = it.probe_id;
        emit_request();
      end
    end else if (cmd != OP_IDLE) begin
      if (it.operation == OP_RX_BYTE) begin
        need = (cmd == OP_RD_BYTE) ? RSP_BYTE : (cmd == OP_RD_WORD) ? RSP_WORD : RSP_STATUS;
        if (rx_cnt < 2 && it.rx_data != HDR_BYTE) hdr_ok = 1'b0;
        if (rx_cnt == 4'd5) data_lo = it.rx_data;
        if (rx_cnt == 4'd6) data_hi = it.rx_data;
        rx_cnt = rx_cnt + 4'd1;
        if (rx_cnt >= need) close_command(hdr_ok ? ST_GOOD : ST_BAD);
      end else if (it.operation == OP_TICK) begin
        if (ticks_left <= 1) close_command(ST_TIMEOUT);
        else ticks_left = ticks_left - 1'b1;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      field_bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_id_q = DEF_START_ID;
      long_to_q  = DEF_LONG_TO;
      short_to_q = DEF_SHORT_TO;
      cur_id     = DEF_START_ID;
      cmd        = OP_IDLE;
      cmd_reg    = 8'd0;
      cmd_value  = 16'd0;
      cmd_probe  = 8'd0;
      rx_cnt     = 4'd0;
      hdr_ok     = 1'b1;
      data_lo    = 8'd0;
      data_hi    = 8'd0;
      ticks_left = '0;
      owed_items_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_START_ID: begin
            start_id_q = cfg_pwdata[7:0];
            cur_id     = cfg_pwdata[7:0];
          end
          REG_LONG_TO:  long_to_q  = cfg_pwdata[15:0];
          REG_SHORT_TO: short_to_q = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) advance_master(in_data);
      if (out_valid && !out_stall) begin
        if (owed_items_q.size() == 0) begin
          $display("%0t: unexpected result item, expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          want      = owed_items_q.pop_front();
          field_bad = 1'b0;
          check_field("result_kind", 16'(want.result_kind), 16'(out_data.result_kind));
          check_field("tx_data", 16'(want.tx_data), 16'(out_data.tx_data));
          check_field("tx_last", 16'(want.tx_last), 16'(out_data.tx_last));
          check_field("status", 16'(want.status), 16'(out_data.status));
          check_field("read_value", want.read_value, out_data.read_value);
          check_field("ping_found", 16'(want.ping_found), 16'(out_data.ping_found));
          if (field_bad) fail_count++;
        end
      end
    end
    owed_count = owed_items_q.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// Top of the servo bus packet master testbench: clock, reset, config writes,
// command/response stimulus and the verdict. Depends on sbpm_pkg, sbpm_checker
// and the servo_bus_packet_master RTL.
`timescale 1ns / 1ps

module tb_top;
  import sbpm_pkg::*;

  localparam int          LIMIT_CYCLES = 600000;
  localparam int          SETTLE_CYCLES = 12;   // longer than the result path plus a packet
  localparam int          LONG_HOLD = 300;      // receiver hold-off, long enough to fill the queue
  localparam int          PHASE_ITEMS = 64;
  localparam logic [7:0]  HDR = 8'hFF;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int   fail_count;
  int   owed_count;
  logic chk_busy;

  int   cycle_count = 0;
  int   items_done = 0;     // items that the block acts on
  int   send_gap_pct = 0;   // sender idle chance per cycle
  int   stall_pct = 0;      // receiver stall chance per cycle
  int   hold_requests = 0;  // long hold-offs asked of the receiver
  int   holds_served = 0;

  servo_bus_packet_master u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sbpm_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .owed_count  (owed_count),
    .busy        (chk_busy)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stalls at the falling edge; a requested long hold-off is
  // counted out here while the sender keeps offering items.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        repeat (LONG_HOLD) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // All fields random, operation forced; unused fields must not matter.
  function automatic in_item_t rand_item(op_t op);
    in_item_t it;
    it.operation   = op;
    it.servo_reg   = 8'($urandom);
    it.write_value = 16'($urandom);
    it.probe_id    = 8'($urandom_range(254));
    it.rx_data     = 8'($urandom);
    return it;
  endfunction

  // Starts and ends at a falling edge. Valid stays high into the next call,
  // so back-to-back items go out with no idle gap between them.
  task automatic drive_item(in_item_t it);
    bit acted;
    acted = (it.operation <= OP_RD_WORD) ? !chk_busy
          : ((it.operation == OP_RX_BYTE || it.operation == OP_TICK) && chk_busy);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (acted) items_done++;
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    in_valid    <= 1'b0;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // sender pauses until every predicted result is out, then waits SETTLE_CYCLES
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (owed_count > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // finish any open command with header bytes, then drain
  task automatic quiesce();
    in_item_t it;
    while (chk_busy) begin
      it = rand_item(OP_RX_BYTE);
      it.rx_data = HDR;
      drive_item(it);
    end
    wait_drained();
  endtask

  task automatic apply_settings(logic [7:0] id, logic [15:0] long_to, logic [15:0] short_to);
    quiesce();
    cfg_write(REG_START_ID, {24'd0, id});
    cfg_write(REG_LONG_TO, {16'd0, long_to});
    cfg_write(REG_SHORT_TO, {16'd0, short_to});
  endtask

  // Response: two header bytes, then random bytes with the odd tick or dropped
  // command mixed in, until the command closes or eight more bytes or ticks went by.
  task automatic answer(input logic [7:0] b0, input logic [7:0] b1,
                        input int tick_pct, input int drop_pct);
    in_item_t it;
    int       n;
    it = rand_item(OP_RX_BYTE);
    it.rx_data = b0;
    drive_item(it);
    it = rand_item(OP_RX_BYTE);
    it.rx_data = b1;
    drive_item(it);
    n = 0;
    while (chk_busy && n < 8) begin
      if ($urandom_range(99) < tick_pct) drive_item(rand_item(OP_TICK));
      else drive_item(rand_item(OP_RX_BYTE));
      if (chk_busy && $urandom_range(99) < drop_pct)
        drive_item(rand_item(op_t'($urandom_range(OP_RD_WORD))));
      n++;
    end
  endtask

  // One command with one of: good response, broken header, timeout, or a
  // partial response cut off by ticks. Always leaves the block idle.
  task automatic run_exchange(bit clean);
    in_item_t it;
    int       mode;
    int       n;
    logic [7:0] bad;
    drive_item(rand_item(op_t'($urandom_range(OP_RD_WORD))));
    mode = clean ? 0 : $urandom_range(99);
    if (mode < 55) begin
      answer(HDR, HDR, 8, 5);
    end else if (mode < 75) begin
      bad = 8'($urandom_range(254));
      if ($urandom_range(1)) answer(bad, HDR, 5, 5);
      else answer(HDR, bad, 5, 5);
    end else if (mode < 90) begin
      n = 0;
      while (chk_busy && n < 40) begin
        drive_item(rand_item(OP_TICK));
        n++;
      end
    end else begin
      repeat ($urandom_range(1, 5)) drive_item(rand_item(OP_RX_BYTE));
      repeat ($urandom_range(1, 4)) drive_item(rand_item(OP_TICK));
    end
    while (chk_busy) begin
      it = rand_item(OP_RX_BYTE);
      it.rx_data = HDR;
      drive_item(it);
    end
  endtask

  // mostly exchanges; the rest is any item at all, often ignored
  task automatic random_phase(int quota);
    int start;
    start = items_done;
    while (items_done - start < quota) begin
      if ($urandom_range(99) < 85) run_exchange(1'b0);
      else drive_item(rand_item(op_t'($urandom_range(OP_IDLE))));
    end
  endtask

  initial begin
    in_item_t it;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed, reset config: items while idle are ignored
    drive_item(rand_item(OP_TICK));
    drive_item(rand_item(OP_RX_BYTE));
    drive_item(rand_item(OP_IDLE));
    // ping of the top id; a good header makes it the current id
    it = rand_item(OP_PING);
    it.probe_id = 8'd254;
    drive_item(it);
    answer(HDR, HDR, 0, 0);
    // word read of the last register, with commands dropped mid-response
    it = rand_item(OP_RD_WORD);
    it.servo_reg = 8'hFF;
    drive_item(it);
    answer(HDR, HDR, 0, 40);
    // byte write of all ones: only the low byte goes out
    it = rand_item(OP_WR_BYTE);
    it.servo_reg   = 8'h00;
    it.write_value = 16'hFFFF;
    drive_item(it);
    answer(8'h00, HDR, 0, 0);

    // Extreme high settings, no idling
    apply_settings(8'd254, 16'hFFFF, 16'hFFFF);
    random_phase(PHASE_ITEMS);

    // Extreme low settings: every tick times out; sender idles
    send_gap_pct = 61;
    apply_settings(8'd0, 16'd1, 16'd1);
    random_phase(PHASE_ITEMS);

    // Short timeouts, receiver stalling
    send_gap_pct = 0;
    stall_pct    = 61;
    apply_settings(8'd17, 16'd3, 16'd2);
    random_phase(PHASE_ITEMS);

    // Random small timeouts, both sides idling now and then
    send_gap_pct = 9;
    stall_pct    = 9;
    apply_settings(8'($urandom_range(254)), 16'($urandom_range(1, 6)),
                   16'($urandom_range(1, 6)));
    random_phase(PHASE_ITEMS);

    // Back-pressure: receiver holds off while clean exchanges pour in, so the
    // job queue fills and the input stalls
    send_gap_pct = 0;
    stall_pct    = 0;
    apply_settings(8'($urandom_range(254)), 16'd500, 16'd100);
    @(posedge clk);
    hold_requests++;
    @(negedge clk);
    repeat (8) run_exchange(1'b1);
    wait_drained();

    // Mixed extremes with both sides idling
    send_gap_pct = 9;
    stall_pct    = 9;
    apply_settings(8'($urandom_range(254)), 16'hFFFF, 16'd1);
    random_phase(PHASE_ITEMS);

    send_gap_pct = 0;
    stall_pct    = 0;
    wait_drained();
    if (fail_count == 0 && owed_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
